// ===== hw/rtl/region_map_frame_allocator_top_defines.svh =====
// assertion macros for the region map frame allocator
// expects clk_i and rst_ni in the scope of every use
`ifndef REGION_MAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH
`define REGION_MAP_FRAME_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define RMFA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define RMFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rmfa_pkg.sv =====
// shared types and constants of the region map frame allocator
// no dependencies
package rmfa_pkg;

  // fixed field widths
  localparam int ADDR_W    = 32;
  localparam int TYPE_W    = 2;
  localparam int SLOT_W    = 3;
  localparam int RCNT_W    = 4;
  localparam int CFG_IDX_W = 2;

  // request codes
  typedef enum logic [TYPE_W-1:0] {
    REQ_LOAD     = 2'd0,
    REQ_ADDR2NUM = 2'd1,
    REQ_NUM2ADDR = 2'd2,
    REQ_ALLOC    = 2'd3
  } req_type_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_START = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_END   = 2'd2;

  // one entry of the region table
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] length;
    logic              reserved;
  } region_entry_t;

endpackage

// ===== hw/rtl/rmfa_if.sv =====
// valid/ready channels of the region map frame allocator
// depends on rmfa_pkg
interface rmfa_req_if;
  import rmfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [SLOT_W-1:0] region_slot;
  logic [ADDR_W-1:0] region_base;
  logic [ADDR_W-1:0] region_length;
  logic              region_reserved;
  logic [ADDR_W-1:0] request_value;

  modport source (
    output valid, req_type, region_slot, region_base, region_length,
           region_reserved, request_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, region_slot, region_base, region_length,
           region_reserved, request_value,
    output ready
  );
endinterface

interface rmfa_rsp_if;
  import rmfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_value;
  logic              found;

  modport source (output valid, result_value, found, input ready);
  modport sink (input valid, result_value, found, output ready);
endinterface

// ===== hw/rtl/region_map_frame_allocator_top.sv =====
// top level of the region map frame allocator
// depends on rmfa_pkg, rmfa_if, rmfa_ram and the assertion macro header
//
// Keeps a table of up to MAX_REGIONS memory regions in a small ram and serves
// one request word at a time: region load, address to frame number, frame
// number to address and bump allocation. A lookup walks the table one entry
// at a time, each entry through the states ram read, chunk count and match.
// An allocation runs one frame to address walk per step, passes the header
// window states for each window skip (at most MAX_REGIONS + 1 steps), and
// ends with one final address to frame walk. A new request word is taken
// while the previous result still waits in the output register.
`include "region_map_frame_allocator_top_defines.svh"

module region_map_frame_allocator_top #(
  parameter int MAX_REGIONS = 8,
  parameter int PAGE_BITS   = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rmfa_req_if.sink                      req_i,
  rmfa_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [rmfa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rmfa_pkg::ADDR_W-1:0]    cfg_wdata_i
);
  import rmfa_pkg::*;

  localparam int AW      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int RIDX_W  = $clog2(MAX_REGIONS + 1);
  localparam int ACT_W   = (RIDX_W > RCNT_W) ? RIDX_W : RCNT_W;
  localparam int CHUNK_W = ADDR_W - PAGE_BITS;
  localparam int KEY_W   = ADDR_W + 1;
  localparam int DIFF_W  = KEY_W + 1;
  localparam int ENTRY_W = $bits(region_entry_t);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CC   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_WIN1 = 3'd4;
  localparam logic [2:0] S_WIN2 = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // control registers
  logic [2:0]        state_q, state_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic [ADDR_W-1:0] next_frame_q, next_frame_d;
  logic [RCNT_W-1:0] region_count_q;
  logic [ADDR_W-1:0] header_start_q, header_end_q;

  // working registers
  req_type_e          op_q, op_d;
  logic               walk_addr_q, walk_addr_d;
  logic [RIDX_W-1:0]  r_q, r_d;
  logic [RIDX_W-1:0]  it_q, it_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [KEY_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]  base_q, base_d;
  logic               resv_q, resv_d;
  logic [CHUNK_W-1:0] chunk_q, chunk_d;
  logic [DIFF_W-1:0]  off_q, off_d;
  logic [ADDR_W-1:0]  aval_q, aval_d;
  logic [CHUNK_W-1:0] kraw_q, kraw_d;
  logic [ADDR_W-1:0]  res_q, res_d;
  logic               ok_q, ok_d;
  logic [ADDR_W-1:0]  rsp_value_q, rsp_value_d;
  logic               rsp_found_q, rsp_found_d;

  // table ram
  logic               ram_we;
  region_entry_t      ram_wentry;
  logic [ENTRY_W-1:0] ram_rdata;
  region_entry_t      ent;

  rmfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_REGIONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(req_i.region_slot)),
    .wdata_i (ram_wentry),
    .raddr_i (r_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ent = region_entry_t'(ram_rdata);

  always_comb begin
    ram_wentry.base     = req_i.region_base;
    ram_wentry.length   = req_i.region_length;
    ram_wentry.reserved = req_i.region_reserved;
  end

  // active entry count, clipped to the table depth
  logic [ACT_W-1:0]  rc_ext;
  logic [RIDX_W-1:0] act_lim;

  assign rc_ext  = ACT_W'(region_count_q);
  assign act_lim = (rc_ext > ACT_W'(MAX_REGIONS)) ? RIDX_W'(MAX_REGIONS) : RIDX_W'(rc_ext);

  // chunk count and offsets from the entry just read
  logic [ADDR_W-1:0] len_m1, span_m1;

  assign len_m1  = ent.length - ADDR_W'(1);
  assign span_m1 = (len_m1 < ~ent.base) ? len_m1 : ~ent.base;

  // match of the current region
  logic [KEY_W-1:0]  pos, chunk_ext, cnt_sum, num_res;
  logic [ADDR_W-1:0] chunk_addr, hdr_gap;
  logic              hit, in_win;

  assign chunk_ext  = KEY_W'(chunk_q);
  assign pos        = walk_addr_q ? off_q[KEY_W-1:0] : KEY_W'(off_q[KEY_W-1:PAGE_BITS]);
  assign hit        = !off_q[DIFF_W-1] && (pos < chunk_ext);
  assign cnt_sum    = cnt_q + chunk_ext;
  assign num_res    = cnt_q + pos + KEY_W'(1);
  assign chunk_addr = base_q + {off_q[CHUNK_W-1:0], {PAGE_BITS{1'b0}}};
  assign in_win     = (aval_q >= header_start_q) && (aval_q <= header_end_q);
  assign hdr_gap    = header_end_q - base_q;

  assign req_i.ready = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d      = state_q;
    rsp_valid_d  = rsp_valid_q;
    next_frame_d = next_frame_q;
    op_d         = op_q;
    walk_addr_d  = walk_addr_q;
    r_d          = r_q;
    it_d         = it_q;
    key_d        = key_q;
    cnt_d        = cnt_q;
    base_d       = base_q;
    resv_d       = resv_q;
    chunk_d      = chunk_q;
    off_d        = off_q;
    aval_d       = aval_q;
    kraw_d       = kraw_q;
    res_d        = res_q;
    ok_d         = ok_q;
    rsp_value_d  = rsp_value_q;
    rsp_found_d  = rsp_found_q;
    ram_we       = 1'b0;

    // result word taken downstream
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d  = req_type_e'(req_i.req_type);
          r_d   = '0;
          cnt_d = '0;
          it_d  = '0;
          res_d = '0;
          ok_d  = 1'b0;
          case (req_type_e'(req_i.req_type))
            REQ_LOAD: begin
              if (int'(req_i.region_slot) < MAX_REGIONS) begin
                ram_we = 1'b1;
                ok_d   = 1'b1;
              end
              state_d = S_FIN;
            end
            REQ_ADDR2NUM: begin
              key_d       = {1'b0, req_i.request_value};
              walk_addr_d = 1'b0;
              state_d     = S_RD;
            end
            REQ_NUM2ADDR: begin
              key_d       = {1'b0, req_i.request_value};
              walk_addr_d = 1'b1;
              state_d     = S_RD;
            end
            REQ_ALLOC: begin
              key_d       = {1'b0, next_frame_q};
              walk_addr_d = 1'b1;
              state_d     = S_RD;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end

      // entry address on the ram, or end of walk
      S_RD: begin
        if ((key_q == '0) || (r_q >= act_lim)) begin
          res_d   = '0;
          ok_d    = 1'b0;
          state_d = S_FIN;
        end else begin
          state_d = S_CC;
        end
      end

      // chunk count and offset of the entry
      S_CC: begin
        base_d  = ent.base;
        resv_d  = ent.reserved;
        chunk_d = (ent.length == '0) ? '0 : span_m1[ADDR_W-1:PAGE_BITS];
        if (walk_addr_q) begin
          off_d = {1'b0, key_q} - {1'b0, cnt_q} - DIFF_W'(1);
        end else begin
          off_d = {2'b00, key_q[ADDR_W-1:0]} - {2'b00, ent.base};
        end
        state_d = S_EV;
      end

      // match against the entry
      S_EV: begin
        if (hit && walk_addr_q && !resv_q) begin
          if (op_q == REQ_ALLOC) begin
            aval_d  = chunk_addr;
            state_d = S_WIN1;
          end else begin
            res_d   = chunk_addr;
            ok_d    = 1'b1;
            state_d = S_FIN;
          end
        end else if (hit && !walk_addr_q) begin
          res_d = num_res[ADDR_W-1:0];
          ok_d  = 1'b1;
          if (op_q == REQ_ALLOC) begin
            next_frame_d = num_res[ADDR_W-1:0] + ADDR_W'(1);
          end
          state_d = S_FIN;
        end else begin
          // reserved region hands the request to the first chunk after it
          if (hit) begin
            key_d = cnt_sum + KEY_W'(1);
          end
          cnt_d   = cnt_sum;
          r_d     = r_q + RIDX_W'(1);
          state_d = S_RD;
        end
      end

      // header window test of the candidate chunk
      S_WIN1: begin
        kraw_d = hdr_gap[ADDR_W-1:PAGE_BITS];
        r_d    = '0;
        if (in_win) begin
          state_d = S_WIN2;
        end else begin
          key_d       = {1'b0, aval_q};
          walk_addr_d = 1'b0;
          cnt_d       = '0;
          state_d     = S_RD;
        end
      end

      // step past the window chunks of this region
      S_WIN2: begin
        if (it_q == RIDX_W'(MAX_REGIONS)) begin
          res_d   = '0;
          ok_d    = 1'b0;
          state_d = S_FIN;
        end else begin
          key_d = (kraw_q >= chunk_q) ? (cnt_sum + KEY_W'(1))
                                      : (cnt_q + KEY_W'(kraw_q) + KEY_W'(2));
          it_d        = it_q + RIDX_W'(1);
          walk_addr_d = 1'b1;
          cnt_d       = '0;
          r_d         = '0;
          state_d     = S_RD;
        end
      end

      // hand the result to the output register
      S_FIN: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_value_d = ok_q ? res_q : '0;
          rsp_found_d = ok_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      rsp_valid_q    <= 1'b0;
      next_frame_q   <= ADDR_W'(1);
      region_count_q <= '0;
      header_start_q <= '0;
      header_end_q   <= '0;
    end else begin
      state_q      <= state_d;
      rsp_valid_q  <= rsp_valid_d;
      next_frame_q <= next_frame_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_REGION_COUNT: region_count_q <= cfg_wdata_i[RCNT_W-1:0];
          CFG_HEADER_START: header_start_q <= cfg_wdata_i;
          CFG_HEADER_END:   header_end_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    walk_addr_q <= walk_addr_d;
    r_q         <= r_d;
    it_q        <= it_d;
    key_q       <= key_d;
    cnt_q       <= cnt_d;
    base_q      <= base_d;
    resv_q      <= resv_d;
    chunk_q     <= chunk_d;
    off_q       <= off_d;
    aval_q      <= aval_d;
    kraw_q      <= kraw_d;
    res_q       <= res_d;
    ok_q        <= ok_d;
    rsp_value_q <= rsp_value_d;
    rsp_found_q <= rsp_found_d;
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.result_value = rsp_value_q;
  assign rsp_o.found        = rsp_found_q;

  // checks on the sequencer
  `RMFA_ASSERT_IMPL(a_walk_in_range, (state_q == S_CC) || (state_q == S_EV), r_q < act_lim, "walk index beyond active regions")
  `RMFA_ASSERT_IMPL(a_key_nonzero, state_q == S_CC, key_q != '0, "walk started with zero key")
  `RMFA_ASSERT_IMPL(a_win_alloc_only, (state_q == S_WIN1) || (state_q == S_WIN2), op_q == REQ_ALLOC, "window step outside allocation")
  `RMFA_ASSERT_IMPL(a_nf_update, !$stable(next_frame_q), ($past(state_q) == S_EV) && ($past(op_q) == REQ_ALLOC), "next frame moved outside allocation")
  `RMFA_ASSERT_IMPL(a_rsp_from_fin, $rose(rsp_valid_q), $past(state_q) == S_FIN, "result word raised outside finish")

endmodule

// ===== hw/rtl/rmfa_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rmfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/tb_region_map_frame_allocator_top.sv =====
`timescale 1ns / 100ps
// self-checking testbench for region_map_frame_allocator_top
// needs rmfa_pkg, rmfa_if and the rtl of the allocator; predicts every result word
// and compares it with what the block returns over the valid/ready channels

module tb_region_map_frame_allocator_top;
  import rmfa_pkg::*;

  localparam int          MAX_REGIONS     = 8;
  localparam int          PAGE_BITS       = 12;
  localparam logic [63:0] ADDR_SPAN       = 64'h1_0000_0000;
  localparam logic [63:0] PAGE_BYTES      = 64'd1 << PAGE_BITS;
  localparam int          MAX_GAP         = 11;
  localparam int          WATCHDOG_CYCLES = 4000;
  localparam int          SETTLE_CYCLES   = 64;
  localparam int          NUM_PHASES      = 10;
  localparam int          PHASE_WORDS     = 50;

  // one request word and one result word
  typedef struct {
    req_type_e   kind;
    logic [2:0]  slot;
    logic [31:0] base;
    logic [31:0] length;
    logic        reserved;
    logic [31:0] value;
  } frame_req_t;

  typedef struct {
    logic [31:0] value;
    logic        found;
  } frame_result_t;

  // region table mirror, frame lookups and the queue of results still owed
  class frame_alloc_scoreboard;
    region_entry_t region_tbl [MAX_REGIONS];
    logic [3:0]    region_count;
    logic [31:0]   hdr_start;
    logic [31:0]   hdr_end;
    logic [31:0]   next_frame;
    frame_result_t pending_results [$];
    int unsigned   mismatches;
    int unsigned   results_checked;
    int unsigned   allocs_granted;
    int unsigned   kind_count [4];

    function new();
      foreach (region_tbl[r]) region_tbl[r] = '0;
      foreach (kind_count[k]) kind_count[k] = 0;
      region_count    = '0;
      hdr_start       = '0;
      hdr_end         = '0;
      next_frame      = 32'd1;
      mismatches      = 0;
      results_checked = 0;
      allocs_granted  = 0;
    endfunction

    function void set_regs(logic [3:0] count, logic [31:0] hs, logic [31:0] he);
      region_count = count;
      hdr_start    = hs;
      hdr_end      = he;
    endfunction

    function int unsigned active_regions();
      return (region_count > MAX_REGIONS) ? MAX_REGIONS : region_count;
    endfunction

    // chunks in a region, (span - 1) >> PAGE_BITS, the end clipped at 4 GiB
    function logic [63:0] chunks_in(int unsigned r);
      logic [63:0] b;
      logic [63:0] stop;
      logic [63:0] span;
      b    = {32'd0, region_tbl[r].base};
      stop = b + {32'd0, region_tbl[r].length};
      if (stop > ADDR_SPAN) stop = ADDR_SPAN;
      span = stop - b;
      if (span <= PAGE_BYTES) return 64'd0;
      return (span - 64'd1) >> PAGE_BITS;
    endfunction

    function logic [63:0] total_chunks();
      logic [63:0] sum;
      sum = 0;
      for (int unsigned r = 0; r < active_regions(); r++) sum += chunks_in(r);
      return sum;
    endfunction

    // frame number to chunk address, reserved regions pass the frame on
    function bit frame_to_addr(input logic [63:0] frame, output logic [63:0] addr,
                               output int unsigned slot, output logic [63:0] prior_frames);
      logic [63:0] want;
      logic [63:0] seen;
      logic [63:0] c;
      want         = frame;
      seen         = 0;
      addr         = 0;
      slot         = 0;
      prior_frames = 0;
      if (want == 0) return 1'b0;
      for (int unsigned r = 0; r < active_regions(); r++) begin
        c = chunks_in(r);
        if (want > seen && want <= seen + c) begin
          if (region_tbl[r].reserved) begin
            want = seen + c + 64'd1;
          end else begin
            addr         = {32'd0, region_tbl[r].base} + ((want - seen - 64'd1) << PAGE_BITS);
            slot         = r;
            prior_frames = seen;
            return 1'b1;
          end
        end
        seen += c;
      end
      return 1'b0;
    endfunction

    // address to frame number, first matching region wins, 0 for none
    function logic [63:0] addr_to_frame(logic [63:0] addr);
      logic [63:0] seen;
      logic [63:0] c;
      logic [63:0] b;
      seen = 0;
      if (addr == 0) return 64'd0;
      for (int unsigned r = 0; r < active_regions(); r++) begin
        c = chunks_in(r);
        b = {32'd0, region_tbl[r].base};
        if (addr >= b && addr < b + (c << PAGE_BITS))
          return seen + ((addr - b) >> PAGE_BITS) + 64'd1;
        seen += c;
      end
      return 64'd0;
    endfunction

    function frame_result_t predict_frame_result(frame_req_t rq);
      frame_result_t res;
      logic [63:0]   n;
      logic [63:0]   a;
      logic [63:0]   prior_frames;
      logic [63:0]   c;
      logic [63:0]   k;
      logic [63:0]   val;
      int unsigned   slot;
      bit            ok;
      ok  = 1'b0;
      val = 0;
      case (rq.kind)
        REQ_LOAD: begin
          region_tbl[rq.slot].base     = rq.base;
          region_tbl[rq.slot].length   = rq.length;
          region_tbl[rq.slot].reserved = rq.reserved;
          ok = 1'b1;
        end
        REQ_ADDR2NUM: begin
          val = addr_to_frame({32'd0, rq.value});
          ok  = (val != 0);
        end
        REQ_NUM2ADDR: begin
          if (frame_to_addr({32'd0, rq.value}, a, slot, prior_frames)) begin
            val = a;
            ok  = 1'b1;
          end
        end
        default: begin
          // bump allocation, jumping over chunks inside the header window
          n = {32'd0, next_frame};
          for (int it = 0; it <= MAX_REGIONS; it++) begin
            if (!frame_to_addr(n, a, slot, prior_frames)) break;
            if (a >= {32'd0, hdr_start} && a <= {32'd0, hdr_end}) begin
              c = chunks_in(slot);
              k = (({32'd0, hdr_end} - {32'd0, region_tbl[slot].base}) >> PAGE_BITS) + 64'd1;
              if (k > c) k = c;
              n = prior_frames + k + 64'd1;
              continue;
            end
            val = addr_to_frame(a);
            if (val != 0) begin
              ok         = 1'b1;
              next_frame = val[31:0] + 32'd1;
              allocs_granted++;
            end
            break;
          end
        end
      endcase
      res.value = ok ? val[31:0] : 32'd0;
      res.found = ok;
      return res;
    endfunction

    function void note_request(frame_req_t rq);
      kind_count[rq.kind]++;
      pending_results.push_back(predict_frame_result(rq));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch in %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [31:0] value, logic found);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", value, 32'd0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (value !== want.value) report_mismatch("result_value", value, want.value);
        if (found !== want.found) report_mismatch("found", {31'd0, found}, {31'd0, want.found});
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ADDR_W-1:0]    cfg_wdata_i;
  bit                   send_quiet;
  bit                   recv_quiet;
  int unsigned          idle_cycles = 0;
  int unsigned          settings_used;

  frame_alloc_scoreboard sb = new();

  rmfa_req_if req_if ();
  rmfa_rsp_if rsp_if ();

  region_map_frame_allocator_top #(
    .MAX_REGIONS (MAX_REGIONS),
    .PAGE_BITS   (PAGE_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic frame_req_t make_request(req_type_e kind, logic [2:0] slot,
                                              logic [31:0] base, logic [31:0] length,
                                              logic reserved, logic [31:0] value);
    frame_req_t rq;
    rq.kind     = kind;
    rq.slot     = slot;
    rq.base     = base;
    rq.length   = length;
    rq.reserved = reserved;
    rq.value    = value;
    return rq;
  endfunction

  // random word: mostly lookups aimed at loaded regions, some loads and allocations
  function automatic frame_req_t random_request();
    frame_req_t    rq;
    int unsigned   pick;
    int unsigned   s;
    logic [31:0]   span;
    logic [63:0]   total;
    rq.slot     = $urandom_range(7, 0);
    rq.base     = $urandom;
    rq.length   = $urandom;
    rq.reserved = $urandom_range(1, 0);
    rq.value    = $urandom;
    pick = $urandom_range(99, 0);
    if (pick < 20)      rq.kind = REQ_LOAD;
    else if (pick < 50) rq.kind = REQ_ADDR2NUM;
    else if (pick < 80) rq.kind = REQ_NUM2ADDR;
    else                rq.kind = REQ_ALLOC;
    pick = $urandom_range(99, 0);
    case (rq.kind)
      REQ_LOAD: begin
        if (pick < 50)
          rq.base = ($urandom_range(63, 0) << PAGE_BITS) +
                    ($urandom_range(1, 0) ? 32'd0 : $urandom_range(32'hFFF, 0));
        else if (pick >= 75)
          rq.base = 32'hFFFF_0000 + ($urandom_range(15, 0) << PAGE_BITS);
        pick = $urandom_range(99, 0);
        if (pick < 50)
          rq.length = ($urandom_range(20, 0) << PAGE_BITS) +
                      ($urandom_range(1, 0) ? 32'd0 : $urandom_range(32'hFFF, 0));
        else if (pick < 80)
          rq.length = $urandom_range(32'h0100_0000, 0);
        rq.reserved = ($urandom_range(3, 0) == 0);
      end
      REQ_ADDR2NUM: begin
        s    = $urandom_range(7, 0);
        span = (sb.region_tbl[s].length > 32'hFFFF_DFFF) ? 32'hFFFF_FFFF :
               sb.region_tbl[s].length + 32'h2000;
        if (pick < 5)       rq.value = 32'd0;
        else if (pick >= 25) rq.value = sb.region_tbl[s].base + $urandom_range(span, 0);
      end
      REQ_NUM2ADDR: begin
        total = sb.total_chunks();
        if (pick < 5)       rq.value = 32'd0;
        else if (pick < 20) rq.value = $urandom;
        else if (pick < 50) rq.value = $urandom_range(40, 1);
        else if (total < 64'hFFFF_FFF0) rq.value = $urandom_range(total[31:0] + 32'd3, 0);
      end
      default: ;
    endcase
    return rq;
  endfunction

  // sender: optional gap, then hold the word until it is taken
  task automatic send_request(frame_req_t rq);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid           <= 1'b1;
    req_if.req_type        <= rq.kind;
    req_if.region_slot     <= rq.slot;
    req_if.region_base     <= rq.base;
    req_if.region_length   <= rq.length;
    req_if.region_reserved <= rq.reserved;
    req_if.request_value   <= rq.value;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    sb.note_request(rq);
  endtask

  // stop sending and wait for every owed result
  task automatic drain_block();
    req_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write all three registers on back-to-back edges, block idle
  task automatic program_regs(logic [3:0] count, logic [31:0] hs, logic [31:0] he);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_REGION_COUNT;
    cfg_wdata_i <= {28'd0, count};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HEADER_START;
    cfg_wdata_i <= hs;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_HEADER_END;
    cfg_wdata_i <= he;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_regs(count, hs, he);
    settings_used++;
  endtask

  // receiver: optional random stall before each result word
  initial begin
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = recv_quiet ? 0 : $urandom_range(MAX_GAP, 0);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_if.valid && rsp_if.ready));
      sb.check_result(rsp_if.result_value, rsp_if.found);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no word moved for %0d cycles, %0d results owed",
               idle_cycles, sb.pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // main sequence
  initial begin
    frame_req_t    dir_q [$];
    logic [3:0]    cnt;
    logic [31:0]   hs;
    logic [31:0]   he;
    logic [63:0]   a;
    logic [63:0]   prior_frames;
    int unsigned   slot;
    settings_used          = 0;
    send_quiet             = 1'b0;
    recv_quiet             = 1'b0;
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= CFG_REGION_COUNT;
    cfg_wdata_i            <= '0;
    req_if.valid           <= 1'b0;
    req_if.req_type        <= REQ_LOAD;
    req_if.region_slot     <= '0;
    req_if.region_base     <= '0;
    req_if.region_length   <= '0;
    req_if.region_reserved <= 1'b0;
    req_if.request_value   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: every lookup misses
    dir_q.push_back(make_request(REQ_ADDR2NUM, 3'd0, 32'd0, 32'd0, 1'b0, 32'h1234));
    dir_q.push_back(make_request(REQ_NUM2ADDR, 3'd0, 32'd0, 32'd0, 1'b0, 32'd1));
    dir_q.push_back(make_request(REQ_ALLOC,    3'd0, 32'd0, 32'd0, 1'b0, 32'd0));
    dir_q.push_back(make_request(REQ_ADDR2NUM, 3'd0, 32'd0, 32'd0, 1'b0, 32'd0));
    // base at zero, reserved unaligned, one page exactly, one chunk, clipped at 4 GiB,
    // reserved at the top, empty, and one overlapping the first region
    dir_q.push_back(make_request(REQ_LOAD, 3'd0, 32'h0000_0000, 32'h0000_5000, 1'b0, 32'd0));
    dir_q.push_back(make_request(REQ_LOAD, 3'd1, 32'h0001_0800, 32'h0000_3000, 1'b1, 32'd0));
    dir_q.push_back(make_request(REQ_LOAD, 3'd2, 32'h0002_0000, 32'h0000_1000, 1'b0, 32'd0));
    dir_q.push_back(make_request(REQ_LOAD, 3'd3, 32'h0003_0000, 32'h0000_1001, 1'b0, 32'd0));
    dir_q.push_back(make_request(REQ_LOAD, 3'd4, 32'h0004_0000, 32'hFFFF_FFFF, 1'b0, 32'd0));
    dir_q.push_back(make_request(REQ_LOAD, 3'd5, 32'hFFFF_0000, 32'h0002_0000, 1'b1, 32'd0));
    dir_q.push_back(make_request(REQ_LOAD, 3'd6, 32'h0000_8000, 32'h0000_0000, 1'b0, 32'd0));
    dir_q.push_back(make_request(REQ_LOAD, 3'd7, 32'h0000_2000, 32'h0000_4000, 1'b0, 32'd0));
    foreach (dir_q[i]) send_request(dir_q[i]);
    dir_q.delete();
    drain_block();
    program_regs(4'd8, 32'h0000_1000, 32'h0000_2FFF);

    // lookups over the full table
    dir_q.push_back(make_request(REQ_ADDR2NUM, 3'd7, '1, '1, 1'b1, 32'd0));
    dir_q.push_back(make_request(REQ_ADDR2NUM, 3'd7, '1, '1, 1'b1, 32'hFFFF_FFFF));
    dir_q.push_back(make_request(REQ_ADDR2NUM, 3'd7, '1, '1, 1'b1, 32'hFFFF_0000));
    dir_q.push_back(make_request(REQ_ADDR2NUM, 3'd0, 32'd0, 32'd0, 1'b0, 32'h0001_0800));
    dir_q.push_back(make_request(REQ_ADDR2NUM, 3'd0, 32'd0, 32'd0, 1'b0, 32'h0000_2000));
    dir_q.push_back(make_request(REQ_ADDR2NUM, 3'd0, 32'd0, 32'd0, 1'b0, 32'h0002_0000));
    dir_q.push_back(make_request(REQ_NUM2ADDR, 3'd0, 32'd0, 32'd0, 1'b0, 32'd0));
    dir_q.push_back(make_request(REQ_NUM2ADDR, 3'd0, 32'd0, 32'd0, 1'b0, 32'd1));
    dir_q.push_back(make_request(REQ_NUM2ADDR, 3'd0, 32'd0, 32'd0, 1'b0, 32'd5));
    dir_q.push_back(make_request(REQ_NUM2ADDR, 3'd0, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF));
    // first chunk sits at address zero, so allocation fails
    dir_q.push_back(make_request(REQ_ALLOC, 3'd0, 32'd0, 32'd0, 1'b0, 32'hFFFF_FFFF));
    foreach (dir_q[i]) send_request(dir_q[i]);
    dir_q.delete();
    drain_block();

    // header window over the first two pages: allocation skips them
    program_regs(4'd8, 32'h0000_0000, 32'h0000_1FFF);
    send_request(make_request(REQ_ALLOC, 3'd0, 32'd0, 32'd0, 1'b0, 32'd0));
    send_request(make_request(REQ_ALLOC, 3'd0, 32'd0, 32'd0, 1'b0, 32'd0));

    // random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_block();
      case (ph)
        0:       begin cnt = 4'd15; hs = 32'h0000_0000; he = 32'hFFFF_FFFF; end
        1:       begin cnt = 4'd0;  hs = 32'hFFFF_FFFF; he = 32'hFFFF_FFFF; end
        2:       begin cnt = 4'd9;  hs = $urandom;      he = $urandom;      end
        default: cnt = $urandom_range(15, 1);
      endcase
      if (ph > 2) begin
        // window around the next chunk that allocation would hand out
        sb.region_count = cnt;
        if (sb.frame_to_addr({32'd0, sb.next_frame}, a, slot, prior_frames)) begin
          hs = a[31:0] - ($urandom_range(1, 0) << PAGE_BITS);
          he = a[31:0] + ($urandom_range(4, 0) << PAGE_BITS) + $urandom_range(32'hFFF, 0);
        end else begin
          hs = 32'hFFFF_FFFF;
          he = 32'd0;
        end
      end
      program_regs(cnt, hs, he);
      send_quiet = (ph % 4 == 1) || (ph % 4 == 3);
      recv_quiet = (ph % 4 == 2) || (ph % 4 == 3);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // in odd phases, hold off mid phase until all results are back
        if (i == PHASE_WORDS / 2 && ph % 2 == 1) drain_block();
        send_request(random_request());
      end
    end

    // wind down
    drain_block();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("run: %0d loads, %0d address lookups, %0d frame lookups, %0d allocations",
             sb.kind_count[REQ_LOAD], sb.kind_count[REQ_ADDR2NUM],
             sb.kind_count[REQ_NUM2ADDR], sb.kind_count[REQ_ALLOC]);
    $display("run: %0d results checked, %0d allocations granted, %0d register settings",
             sb.results_checked, sb.allocs_granted, settings_used);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== region_map_frame_allocator_top.f =====
+incdir+hw/rtl
hw/rtl/rmfa_pkg.sv
hw/rtl/rmfa_if.sv
hw/rtl/rmfa_ram.sv
hw/rtl/region_map_frame_allocator_top.sv
sim/tb_region_map_frame_allocator_top.sv
